### src/tie_pkg.sv
`default_nettype none
package tie_pkg;
    localparam int ModeW = 5;
    localparam int RegIdxW = 4;
    localparam int ImmW = 32;
    localparam int PcW = 16;
    localparam logic [PcW-1:0] ResetPc = 16'd4000;

    typedef enum logic [ModeW-1:0] {
        OP_NOP = 5'd0, OP_MOVC = 5'd1, OP_ADD = 5'd2, OP_ADDL = 5'd3,
        OP_SUB = 5'd4, OP_SUBL = 5'd5, OP_MUL = 5'd6, OP_AND = 5'd7,
        OP_OR = 5'd8, OP_XOR = 5'd9, OP_LOAD = 5'd10, OP_LDR = 5'd11,
        OP_STORE = 5'd12, OP_STR = 5'd13, OP_BZ = 5'd14, OP_BNZ = 5'd15,
        OP_JUMP = 5'd16, OP_HALT = 5'd17
    } op_t;

    typedef struct packed {
        logic [ModeW-1:0]   mode;
        logic [RegIdxW-1:0] rd;
        logic [RegIdxW-1:0] rs1;
        logic [RegIdxW-1:0] rs2;
        logic [ImmW-1:0]    imm;
    } instr_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_LOAD  = 2'd1,
        ST_CLEAR = 2'd2
    } state_t;
endpackage
`default_nettype wire

### src/teaching_isa_execute_unit_core.sv
`default_nettype none
// channel   | direction | payload
// s_axis    | in        | tdata: mode, dest_reg, src1_reg, src2_reg, immediate (56 bits)
// m_axis    | out       | tdata: next_pc, reg_write, written_reg, written_value,
//           |           |        zero_out, branch_taken, halted_out, address_error
// cfg       | in        | start_pc, also loads the pc at once
// one word per cycle for most instructions unless the output stalls; an in-range
// load or ldr adds ST_LOAD (synchronous data ram read); the register file and pc
// loop needs no stall; after reset a clearing pass zeroes data memory, no word taken
// a two-word queue parts the front from the execute stage, an output register
// holds the result so a stalled master side only blocks once the queue fills
module teaching_isa_execute_unit_core #(
    parameter int NUM_REGS = 16,
    parameter int MEM_WORDS = 4096,
    parameter int DATA_WIDTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire [15:0]  cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[4:0], dest_reg[8:5], src1_reg[12:9], src2_reg[16:13], immediate[48:17]
    input  wire [55:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // next_pc[15:0], reg_write[16], written_reg[20:17], written_value[52:21],
    // zero_out[53], branch_taken[54], halted_out[55], address_error[56]
    output logic [63:0] m_axis_tdata
);
    tie_pkg::instr_t in_w, q_w;
    logic q_valid, q_ready;
    logic [15:0] r_pc;
    logic r_wr, r_zero, r_taken, r_halt, r_aerr;
    logic [3:0] r_reg;
    logic [31:0] r_val;

    assign in_w.mode = s_axis_tdata[4:0];
    assign in_w.rd   = s_axis_tdata[8:5];
    assign in_w.rs1  = s_axis_tdata[12:9];
    assign in_w.rs2  = s_axis_tdata[16:13];
    assign in_w.imm  = s_axis_tdata[48:17];

    tie_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_word(in_w),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_w));

    tie_back #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS),
               .DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_w),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_pc(r_pc), .res_wr(r_wr), .res_reg(r_reg), .res_val(r_val),
        .res_zero(r_zero), .res_taken(r_taken), .res_halt(r_halt),
        .res_aerr(r_aerr));

    assign m_axis_tdata = {7'd0, r_aerr, r_halt, r_taken, r_zero, r_val,
                           r_reg, r_wr, r_pc};
endmodule
`default_nettype wire

### src/tie_ram.sv
`default_nettype none
module tie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/tie_front.sv
`default_nettype none
// two-entry queue of accepted words
module tie_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire tie_pkg::instr_t in_word,
    output logic                 q_valid,
    input  wire                  q_ready,
    output tie_pkg::instr_t      q_word
);
    tie_pkg::instr_t buf_reg [2];
    logic rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_word   = buf_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= in_word;
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### src/tie_back.sv
`default_nettype none
module tie_back #(
    parameter int NUM_REGS = 16,
    parameter int MEM_WORDS = 4096,
    parameter int DATA_WIDTH = 32
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_we,
    input  wire [tie_pkg::PcW-1:0]     cfg_wdata,
    input  wire                        q_valid,
    output logic                       q_ready,
    input  wire tie_pkg::instr_t       q_word,
    output logic                       res_valid,
    input  wire                        res_ready,
    output logic [tie_pkg::PcW-1:0]    res_pc,
    output logic                       res_wr,
    output logic [tie_pkg::RegIdxW-1:0] res_reg,
    output logic [31:0]                res_val,
    output logic                       res_zero,
    output logic                       res_taken,
    output logic                       res_halt,
    output logic                       res_aerr
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam int RW = ($clog2(NUM_REGS) > tie_pkg::RegIdxW) ? tie_pkg::RegIdxW
                                                              : $clog2(NUM_REGS);
    localparam int PW = tie_pkg::PcW;

    logic [DATA_WIDTH-1:0] rf_reg [NUM_REGS];
    logic zero_reg, halt_reg;
    logic [PW-1:0] pc_reg;
    tie_pkg::state_t state_reg, state_next;
    logic [AW:0] clr_reg;
    logic ld_rd_reg;
    logic [3:0] ld_idx_reg;
    logic [PW-1:0] ld_pc_reg;

    logic ov_reg, ov_wr_reg, ov_zero_reg, ov_taken_reg, ov_halt_reg, ov_aerr_reg;
    logic [PW-1:0] ov_pc_reg;
    logic [3:0] ov_reg_reg;
    logic [31:0] ov_val_reg;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata, st_data;

    tie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_WORDS)) u_ram (
        .clk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata));

    function automatic logic [31:0] to32(logic [DATA_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return w[31:0];
    endfunction

    logic [DATA_WIDTH-1:0] a, b, c, imm_x, val, asum, mres;
    logic take, wr, setz, taken, aerr, isld, isst, addr_ok, z_new;
    logic [PW-1:0] npc;
    tie_pkg::op_t op;

    assign op = tie_pkg::op_t'(q_word.mode);
    assign a = (32'(q_word.rs1) < NUM_REGS) ? rf_reg[q_word.rs1[RW-1:0]] : '0;
    assign b = (32'(q_word.rs2) < NUM_REGS) ? rf_reg[q_word.rs2[RW-1:0]] : '0;
    assign c = (32'(q_word.rd) < NUM_REGS) ? rf_reg[q_word.rd[RW-1:0]] : '0;
    assign imm_x = DATA_WIDTH'(64'(signed'(q_word.imm)));
    assign mres = a * b;
    assign q_ready = (state_reg == tie_pkg::ST_RUN) && (!ov_reg || res_ready);
    assign take = q_valid && q_ready;

    always_comb begin
        unique case (op)
            tie_pkg::OP_LOAD:  asum = a + imm_x;
            tie_pkg::OP_STORE: asum = b + imm_x;
            default:           asum = a + b;
        endcase
        addr_ok = !asum[DATA_WIDTH-1] && (65'(asum) < 65'(MEM_WORDS));
    end

    always_comb begin
        val = '0; wr = 1'b0; setz = 1'b0; taken = 1'b0; aerr = 1'b0;
        isld = 1'b0; isst = 1'b0;
        npc = pc_reg + PW'(4);
        st_data = a;
        unique case (op)
            tie_pkg::OP_MOVC: begin val = imm_x; wr = 1'b1; end
            tie_pkg::OP_ADD:  begin val = a + b; wr = 1'b1; setz = 1'b1; end
            tie_pkg::OP_ADDL: begin val = a + imm_x; wr = 1'b1; end
            tie_pkg::OP_SUB:  begin val = a - b; wr = 1'b1; setz = 1'b1; end
            tie_pkg::OP_SUBL: begin val = a - imm_x; wr = 1'b1; end
            tie_pkg::OP_MUL:  begin val = mres; wr = 1'b1; setz = 1'b1; end
            tie_pkg::OP_AND:  begin val = a & b; wr = 1'b1; end
            tie_pkg::OP_OR:   begin val = a | b; wr = 1'b1; end
            tie_pkg::OP_XOR:  begin val = a ^ b; wr = 1'b1; end
            tie_pkg::OP_LOAD, tie_pkg::OP_LDR: begin
                isld = addr_ok; aerr = !addr_ok;
            end
            tie_pkg::OP_STORE: begin isst = addr_ok; aerr = !addr_ok; end
            tie_pkg::OP_STR: begin
                isst = addr_ok; aerr = !addr_ok; st_data = c;
            end
            tie_pkg::OP_BZ: if (zero_reg) begin
                npc = pc_reg + q_word.imm[PW-1:0]; taken = 1'b1;
            end
            tie_pkg::OP_BNZ: if (!zero_reg) begin
                npc = pc_reg + q_word.imm[PW-1:0]; taken = 1'b1;
            end
            tie_pkg::OP_JUMP: begin
                npc = pc_reg + PW'(a) + q_word.imm[PW-1:0]; taken = 1'b1;
            end
            tie_pkg::OP_HALT: npc = pc_reg;
            default: ;
        endcase
        if (32'(q_word.rd) >= NUM_REGS) wr = 1'b0;
        if (setz) z_new = (val == '0);
        else if (op == tie_pkg::OP_BZ) z_new = 1'b0;
        else z_new = zero_reg;
    end

    always_comb begin
        mem_raddr = AW'(asum);
        if (state_reg == tie_pkg::ST_CLEAR) begin
            mem_we = 1'b1; mem_waddr = clr_reg[AW-1:0]; mem_wdata = '0;
        end else begin
            mem_we = take && !halt_reg && isst;
            mem_waddr = AW'(asum);
            mem_wdata = st_data;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tie_pkg::ST_CLEAR: if (clr_reg == (AW+1)'(MEM_WORDS-1))
                state_next = tie_pkg::ST_RUN;
            tie_pkg::ST_RUN: if (take && !halt_reg && isld)
                state_next = tie_pkg::ST_LOAD;
            tie_pkg::ST_LOAD: state_next = tie_pkg::ST_RUN;
            default: state_next = tie_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tie_pkg::ST_CLEAR;
            clr_reg <= '0;
            zero_reg <= 1'b0; halt_reg <= 1'b0;
            pc_reg <= tie_pkg::ResetPc;
            ov_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) rf_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tie_pkg::ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (ov_reg && res_ready) ov_reg <= 1'b0;
            if (state_reg == tie_pkg::ST_LOAD) begin
                ov_reg <= 1'b1;
                ov_pc_reg <= ld_pc_reg; ov_wr_reg <= ld_rd_reg;
                ov_reg_reg <= ld_rd_reg ? ld_idx_reg : 4'd0;
                ov_val_reg <= ld_rd_reg ? to32(mem_rdata) : 32'd0;
                ov_zero_reg <= zero_reg; ov_taken_reg <= 1'b0;
                ov_halt_reg <= 1'b0; ov_aerr_reg <= 1'b0;
                if (ld_rd_reg) rf_reg[ld_idx_reg[RW-1:0]] <= mem_rdata;
            end else if (take) begin
                if (halt_reg) begin
                    ov_reg <= 1'b1; ov_pc_reg <= pc_reg; ov_wr_reg <= 1'b0;
                    ov_reg_reg <= 4'd0; ov_val_reg <= 32'd0;
                    ov_zero_reg <= zero_reg; ov_taken_reg <= 1'b0;
                    ov_halt_reg <= 1'b1; ov_aerr_reg <= 1'b0;
                end else begin
                    pc_reg <= npc;
                    zero_reg <= z_new;
                    if (op == tie_pkg::OP_HALT) halt_reg <= 1'b1;
                    if (wr) rf_reg[q_word.rd[RW-1:0]] <= val;
                    ld_pc_reg <= npc;
                    ld_rd_reg <= (32'(q_word.rd) < NUM_REGS);
                    ld_idx_reg <= q_word.rd;
                    // loads report from the ST_LOAD state, once the ram word is back
                    if (!isld) begin
                        ov_reg <= 1'b1; ov_pc_reg <= npc; ov_wr_reg <= wr;
                        ov_reg_reg <= wr ? q_word.rd : 4'd0;
                        ov_val_reg <= wr ? to32(val) : 32'd0;
                        ov_zero_reg <= z_new; ov_taken_reg <= taken;
                        ov_halt_reg <= (op == tie_pkg::OP_HALT);
                        ov_aerr_reg <= aerr;
                    end
                end
            end
            if (cfg_we) pc_reg <= cfg_wdata;
        end
    end

    assign res_valid = ov_reg;
    assign res_pc = ov_pc_reg;
    assign res_wr = ov_wr_reg;
    assign res_reg = ov_reg_reg;
    assign res_val = ov_val_reg;
    assign res_zero = ov_zero_reg;
    assign res_taken = ov_taken_reg;
    assign res_halt = ov_halt_reg;
    assign res_aerr = ov_aerr_reg;
endmodule
`default_nettype wire

### dv/teaching_isa_execute_unit_core_tb.sv
`default_nettype none
module teaching_isa_execute_unit_core_tb;

    localparam int NumRegs = 16;
    localparam int MemWords = 4096;
    localparam int WatchdogLimit = 20000;

    // one expected result word
    typedef struct packed {
        logic        addr_err;
        logic        halted;
        logic        taken;
        logic        zero;
        logic [31:0] wval;
        logic [3:0]  wreg;
        logic        wen;
        logic [15:0] npc;
    } exec_res_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // mode, dest_reg, src1_reg, src2_reg, immediate
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // next_pc, reg_write, written_reg, written_value, zero_out, branch_taken,
    // halted_out, address_error
    logic [63:0] m_axis_tdata;

    teaching_isa_execute_unit_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // shadow copy of the architectural state
    logic [31:0] gpr [NumRegs];
    logic [31:0] dmem [MemWords];
    logic        zflag;
    logic [15:0] pc_q;
    logic        halt_q;

    exec_res_t   pending_res[$];
    int          fail_count;
    int          words_sent;
    int          words_checked;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    // word address check: signed 32-bit sum inside memory
    function automatic logic addr_ok(input logic [31:0] sum);
        return !sum[31] && (sum < MemWords);
    endfunction

    // work out the result of one instruction and advance the shadow state
    function automatic exec_res_t execute_instr(input logic [4:0] mode, input logic [3:0] rd,
                                                input logic [3:0] rs1, input logic [3:0] rs2,
                                                input logic [31:0] imm);
        exec_res_t   r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        logic [31:0] sum;
        logic        wr;
        logic        setz;
        r = '0;
        a = gpr[rs1];
        b = gpr[rs2];
        v = '0;
        wr = 1'b0;
        setz = 1'b0;
        if (halt_q) begin
            r.npc = pc_q;
            r.zero = zflag;
            r.halted = 1'b1;
            return r;
        end
        r.npc = pc_q + 16'd4;
        case (mode)
            tie_pkg::OP_MOVC: begin v = imm; wr = 1'b1; end
            tie_pkg::OP_ADD:  begin v = a + b; wr = 1'b1; setz = 1'b1; end
            tie_pkg::OP_ADDL: begin v = a + imm; wr = 1'b1; end
            tie_pkg::OP_SUB:  begin v = a - b; wr = 1'b1; setz = 1'b1; end
            tie_pkg::OP_SUBL: begin v = a - imm; wr = 1'b1; end
            tie_pkg::OP_MUL:  begin v = a * b; wr = 1'b1; setz = 1'b1; end
            tie_pkg::OP_AND:  begin v = a & b; wr = 1'b1; end
            tie_pkg::OP_OR:   begin v = a | b; wr = 1'b1; end
            tie_pkg::OP_XOR:  begin v = a ^ b; wr = 1'b1; end
            tie_pkg::OP_LOAD, tie_pkg::OP_LDR: begin
                sum = (mode == tie_pkg::OP_LOAD) ? a + imm : a + b;
                if (addr_ok(sum)) begin
                    v = dmem[sum[11:0]];
                    wr = 1'b1;
                end else begin
                    r.addr_err = 1'b1;
                end
            end
            tie_pkg::OP_STORE: begin
                sum = b + imm;
                if (addr_ok(sum)) dmem[sum[11:0]] = a;
                else r.addr_err = 1'b1;
            end
            tie_pkg::OP_STR: begin
                sum = a + b;
                if (addr_ok(sum)) dmem[sum[11:0]] = gpr[rd];
                else r.addr_err = 1'b1;
            end
            tie_pkg::OP_BZ: begin
                if (zflag) begin
                    r.npc = pc_q + imm[15:0];
                    r.taken = 1'b1;
                    zflag = 1'b0;
                end
            end
            tie_pkg::OP_BNZ: begin
                if (!zflag) begin
                    r.npc = pc_q + imm[15:0];
                    r.taken = 1'b1;
                end
            end
            tie_pkg::OP_JUMP: begin
                r.npc = pc_q + a[15:0] + imm[15:0];
                r.taken = 1'b1;
            end
            tie_pkg::OP_HALT: begin
                halt_q = 1'b1;
                r.npc = pc_q;
            end
            default: ;
        endcase
        if (setz) zflag = (v == 32'd0);
        if (wr) begin
            gpr[rd] = v;
            r.wen = 1'b1;
            r.wreg = rd;
            r.wval = v;
        end
        pc_q = r.npc;
        r.zero = zflag;
        r.halted = halt_q;
        return r;
    endfunction

    task automatic shadow_reset(input logic [15:0] spc);
        for (int i = 0; i < NumRegs; i++) gpr[i] = '0;
        for (int i = 0; i < MemWords; i++) dmem[i] = '0;
        zflag = 1'b0;
        pc_q = spc;
        halt_q = 1'b0;
    endtask

    // send one instruction word, with random sender idling
    task automatic send_instr(input logic [4:0] mode, input logic [3:0] rd,
                              input logic [3:0] rs1, input logic [3:0] rs2,
                              input logic [31:0] imm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {imm, rs2, rs1, rd, mode};
        pending_res.push_back(execute_instr(mode, rd, rs1, rs2, imm));
        words_sent++;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_op(input tie_pkg::op_t op, input logic [3:0] rd,
                           input logic [3:0] rs1, input logic [3:0] rs2,
                           input logic [31:0] imm);
        send_instr(op, rd, rs1, rs2, imm);
    endtask

    // wait for all results with the input idle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // rewrite start_pc while idle; the pc follows at once
    task automatic write_start_pc(input logic [15:0] spc);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= spc;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pc_q = spc;
    endtask

    // random instruction, biased toward small addresses and useful values
    task automatic send_random_instr(input bit allow_halt);
        logic [4:0]  mode;
        logic [31:0] imm;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 3) mode = 5'($urandom_range(31, 18));
        else mode = 5'($urandom_range(allow_halt ? 17 : 16));
        case ($urandom_range(5))
            0: imm = $urandom;
            1: imm = $urandom_range(MemWords - 1);
            2: imm = $urandom_range(MemWords + 8, MemWords - 8);
            3: imm = -$urandom_range(16);
            4: imm = {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: imm = $urandom_range(64);
        endcase
        // often put one small value in a register so more sums stay in range
        if ((mode == tie_pkg::OP_LOAD || mode == tie_pkg::OP_LDR ||
             mode == tie_pkg::OP_STORE || mode == tie_pkg::OP_STR)
            && $urandom_range(3) != 0) begin
            send_op(tie_pkg::OP_MOVC, 4'($urandom), 4'd0, 4'd0,
                    $urandom_range(MemWords / 2));
        end
        send_instr(mode, 4'($urandom), 4'($urandom), 4'($urandom), imm);
    endtask

    task automatic test_directed;
        send_op(tie_pkg::OP_NOP, 4'd0, 4'd0, 4'd0, 32'd0);
        send_op(tie_pkg::OP_MOVC, 4'd1, 4'd0, 4'd0, 32'h7fff_ffff);
        send_op(tie_pkg::OP_MOVC, 4'd2, 4'd0, 4'd0, 32'h8000_0000);
        send_op(tie_pkg::OP_MOVC, 4'd15, 4'd0, 4'd0, 32'hffff_ffff);
        send_op(tie_pkg::OP_ADD, 4'd3, 4'd1, 4'd2, 32'd0);
        send_op(tie_pkg::OP_ADD, 4'd4, 4'd15, 4'd15, 32'd0);
        send_op(tie_pkg::OP_ADDL, 4'd5, 4'd1, 4'd0, 32'd1);
        send_op(tie_pkg::OP_SUB, 4'd6, 4'd1, 4'd1, 32'd0);       // zero flag set
        send_op(tie_pkg::OP_BZ, 4'd0, 4'd0, 4'd0, 32'hffff_fff0); // taken, clears flag
        send_op(tie_pkg::OP_BZ, 4'd0, 4'd0, 4'd0, 32'd64);        // not taken
        send_op(tie_pkg::OP_BNZ, 4'd0, 4'd0, 4'd0, 32'd8);
        send_op(tie_pkg::OP_SUBL, 4'd7, 4'd2, 4'd0, 32'd1);
        send_op(tie_pkg::OP_MUL, 4'd8, 4'd2, 4'd2, 32'd0);
        send_op(tie_pkg::OP_BNZ, 4'd0, 4'd0, 4'd0, 32'd8);        // flag set, not taken
        send_op(tie_pkg::OP_AND, 4'd9, 4'd1, 4'd15, 32'd0);
        send_op(tie_pkg::OP_OR, 4'd10, 4'd1, 4'd2, 32'd0);
        send_op(tie_pkg::OP_XOR, 4'd11, 4'd15, 4'd1, 32'd0);
        send_op(tie_pkg::OP_MOVC, 4'd12, 4'd0, 4'd0, MemWords - 1);
        send_op(tie_pkg::OP_STORE, 4'd0, 4'd1, 4'd12, 32'd0);     // top word
        send_op(tie_pkg::OP_LOAD, 4'd13, 4'd12, 4'd0, 32'd0);
        send_op(tie_pkg::OP_LOAD, 4'd14, 4'd12, 4'd0, 32'd1);     // one past the end
        send_op(tie_pkg::OP_STR, 4'd2, 4'd2, 4'd0, 32'd0);        // negative address
        send_op(tie_pkg::OP_LOAD, 4'd3, 4'd0, 4'd0, 32'hffff_ffff);
        send_op(tie_pkg::OP_JUMP, 4'd0, 4'd15, 4'd0, 32'h7fff_fff0);
    endtask

    // halt mark only clears by reset, so halts go in only at the very end
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_random_instr(1'b0);
    endtask

    task automatic test_halt_tail;
        send_op(tie_pkg::OP_HALT, 4'd0, 4'd0, 4'd0, 32'd0);
        for (int i = 0; i < 20; i++) send_random_instr(1'b1);
    endtask

    // result checker
    always @(posedge aclk) begin
        exec_res_t got;
        exec_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[56:0];
            idle_cycles <= 0;
            words_checked++;
            if (pending_res.size() == 0) begin
                $error("result with nothing expected: %h", got);
                fail_count++;
            end else begin
                want = pending_res.pop_front();
                if (got.npc != want.npc) begin
                    $error("next_pc exp %h got %h", want.npc, got.npc); fail_count++;
                end
                if (got.wen != want.wen) begin
                    $error("reg_write exp %b got %b", want.wen, got.wen); fail_count++;
                end
                if (got.wreg != want.wreg) begin
                    $error("written_reg exp %0d got %0d", want.wreg, got.wreg); fail_count++;
                end
                if (got.wval != want.wval) begin
                    $error("written_value exp %h got %h", want.wval, got.wval); fail_count++;
                end
                if (got.zero != want.zero) begin
                    $error("zero_out exp %b got %b", want.zero, got.zero); fail_count++;
                end
                if (got.taken != want.taken) begin
                    $error("branch_taken exp %b got %b", want.taken, got.taken); fail_count++;
                end
                if (got.halted != want.halted) begin
                    $error("halted_out exp %b got %b", want.halted, got.halted); fail_count++;
                end
                if (got.addr_err != want.addr_err) begin
                    $error("address_error exp %b got %b", want.addr_err, got.addr_err);
                    fail_count++;
                end
            end
        end else if (s_axis_tvalid && s_axis_tready) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WatchdogLimit) begin
            $display("FAIL teaching_isa_execute_unit_core");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        fail_count = 0;
        words_sent = 0;
        words_checked = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_reset(tie_pkg::ResetPc);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // the clearing pass after reset stalls execution; tready holds off input once the queue fills
        test_directed();

        write_start_pc(16'h0000);
        test_random(405);
        send_idle_pct = 79;
        write_start_pc(16'hffff);
        test_random(405);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        write_start_pc(16'h8000 | 16'($urandom));
        test_random(405);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        write_start_pc(16'($urandom));
        test_random(405);
        test_halt_tail();

        drain();
        $display("covered %0d instructions, %0d results checked, all opcodes and",
                 words_sent, words_checked);
        $display("start_pc extremes, address faults, branches and halt");
        if (fail_count == 0 && pending_res.size() == 0) begin
            $display("PASS teaching_isa_execute_unit_core");
        end else begin
            $display("FAIL teaching_isa_execute_unit_core");
        end
        $finish;
    end
endmodule
`default_nettype wire
